@@ rtl/lcdns_pkg.sv @@
// Shared types, codes and tables for the character LCD nibble sequencer.
// Used by lcdns_front, lcdns_back and char_lcd_nibble_sequencer_top.
`default_nettype none
package lcdns_pkg;

  // request codes on in_operation
  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_CMD    = 3'd1;
  localparam logic [2:0] OP_DATA   = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_CURSOR = 3'd4;
  localparam logic [2:0] OP_SCROLL = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_ROWS    = 2'd0;
  localparam logic [1:0] CFG_COLUMNS = 2'd1;
  localparam logic [1:0] CFG_FONT    = 2'd2;

  // descriptor kinds handed from front to back
  localparam logic KIND_INIT  = 1'b0;
  localparam logic KIND_BYTES = 1'b1;

  // command bytes and nibbles
  localparam logic [7:0] BYTE_CLEAR   = 8'h01;
  localparam logic [7:0] BYTE_HOME    = 8'h02;
  localparam logic [7:0] BYTE_DISPLAY = 8'h0C;
  localparam logic [7:0] BYTE_ENTRY   = 8'h06;
  localparam logic [7:0] BYTE_SCROLL  = 8'h18;
  localparam logic [3:0] NIB_WAKE     = 4'h3;
  localparam logic [3:0] NIB_4BIT     = 4'h2;
  localparam logic [3:0] FS_LINES     = 4'h8;
  localparam logic [3:0] FS_FONT      = 4'h4;

  // DDRAM line offsets
  localparam logic [6:0] OFF_LINE0 = 7'h00;
  localparam logic [6:0] OFF_LINE1 = 7'h40;
  localparam logic [6:0] OFF_LINE2 = 7'h14;
  localparam logic [6:0] OFF_LINE3 = 7'h54;

  localparam logic [17:0] WAIT_CLEAR = 18'd1000;
  localparam logic [17:0] US_PER_MS  = 18'd1000;
  localparam logic [3:0]  INIT_LAST  = 4'd11;

  typedef logic [3:0]  step_t;
  typedef logic [17:0] wait_t;

  // one queued request, already classified
  typedef struct packed {
    logic       kind;     // KIND_INIT or KIND_BYTES
    logic       rs;       // register select for all strobes
    logic       pre;      // send byte_a once before the repeated byte
    logic [7:0] byte_a;
    logic [7:0] byte_b;   // repeated reps times
    wait_t      wait_b;   // wait after low nibble of byte_b
    logic [5:0] reps;
    logic [3:0] fs;       // function-set nibble for init
  } desc_t;

  // power-up sequence nibbles
  function automatic logic [3:0] init_nibble(input step_t step, input logic [3:0] fs);
    logic [3:0] n;
    case (step)
      4'd0, 4'd1, 4'd2: n = NIB_WAKE;
      4'd3, 4'd4:       n = NIB_4BIT;
      4'd5:             n = fs;
      4'd6:             n = BYTE_DISPLAY[7:4];
      4'd7:             n = BYTE_DISPLAY[3:0];
      4'd8:             n = BYTE_CLEAR[7:4];
      4'd9:             n = BYTE_CLEAR[3:0];
      4'd10:            n = BYTE_ENTRY[7:4];
      4'd11:            n = BYTE_ENTRY[3:0];
      default:          n = 4'h0;
    endcase
    return n;
  endfunction

  // power-up sequence waits in microseconds
  function automatic wait_t init_wait(input step_t step);
    wait_t w;
    case (step)
      4'd0, 4'd2: w = 18'd5000;
      4'd1:       w = 18'd100;
      4'd5, 4'd7: w = 18'd60;
      4'd9:       w = WAIT_CLEAR;
      default:    w = 18'd0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ rtl/lcdns_front.sv @@
// Front end: accepts requests, classifies them into descriptors and
// queues them. Depends on lcdns_pkg.
`default_nettype none
module lcdns_front #(
  parameter int MAX_SCROLL = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic [2:0]           in_operation,
  input  wire logic [7:0]           in_byte_value,
  input  wire logic [1:0]           in_line,
  input  wire logic [5:0]           in_column,
  input  wire logic [5:0]           in_repeat_count,
  input  wire logic [7:0]           in_pause_ms,
  input  wire logic [2:0]           rows,
  input  wire logic [5:0]           columns,
  input  wire logic                 large_font,
  output logic                      desc_valid,
  output lcdns_pkg::desc_t          desc,
  input  wire logic                 desc_pop
);

  localparam logic [5:0] MaxReps = 6'(MAX_SCROLL);

  lcdns_pkg::desc_t q_mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  lcdns_pkg::desc_t dec;
  logic             dec_keep;
  logic [5:0]       maxc, col_c, cnt_c;
  logic [6:0]       off, addr;
  logic             accept, wr, rd;

  assign in_full    = (count_r == 2'd2);
  assign accept     = in_push && !in_full;
  assign desc_valid = (count_r != 2'd0);
  assign desc       = q_mem[rd_ptr_r];

  // cursor address and scroll count
  always_comb begin
    maxc  = (columns == 6'd0) ? 6'd0 : columns - 6'd1;
    col_c = (in_column > maxc) ? maxc : in_column;
    case (in_line)
      2'd0:    off = lcdns_pkg::OFF_LINE0;
      2'd1:    off = lcdns_pkg::OFF_LINE1;
      2'd2:    off = lcdns_pkg::OFF_LINE2;
      default: off = lcdns_pkg::OFF_LINE3;
    endcase
    addr  = {1'b0, col_c} + off;
    cnt_c = (in_repeat_count > MaxReps) ? MaxReps : in_repeat_count;
  end

  // classify request
  always_comb begin
    dec.kind   = lcdns_pkg::KIND_BYTES;
    dec.rs     = 1'b0;
    dec.pre    = 1'b0;
    dec.byte_a = lcdns_pkg::BYTE_HOME;
    dec.byte_b = in_byte_value;
    dec.wait_b = 18'd0;
    dec.reps   = 6'd1;
    dec.fs     = ((rows > 3'd1) ? lcdns_pkg::FS_LINES : 4'h0)
               | (large_font ? lcdns_pkg::FS_FONT : 4'h0);
    dec_keep   = 1'b1;
    case (in_operation)
      lcdns_pkg::OP_INIT:  dec.kind = lcdns_pkg::KIND_INIT;
      lcdns_pkg::OP_CMD:   dec.rs = 1'b0;
      lcdns_pkg::OP_DATA:  dec.rs = 1'b1;
      lcdns_pkg::OP_CLEAR: begin
        dec.byte_b = lcdns_pkg::BYTE_CLEAR;
        dec.wait_b = lcdns_pkg::WAIT_CLEAR;
      end
      lcdns_pkg::OP_CURSOR: begin
        dec.pre    = 1'b1;
        dec.byte_b = {1'b1, addr};
      end
      lcdns_pkg::OP_SCROLL: begin
        dec.byte_b = lcdns_pkg::BYTE_SCROLL;
        dec.wait_b = 18'(in_pause_ms) * lcdns_pkg::US_PER_MS;
        dec.reps   = cnt_c;
        dec_keep   = (cnt_c != 6'd0);
      end
      default: dec_keep = 1'b0;
    endcase
  end

  // two-entry descriptor queue
  assign wr = accept && dec_keep;
  assign rd = desc_pop && desc_valid;

  always_comb begin
    wr_ptr_nxt = wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_mem[wr_ptr_r] <= dec;
    end
  end

endmodule
`default_nettype wire

@@ rtl/lcdns_back.sv @@
// Back end: takes one descriptor at a time and plays out its strobes
// into the result register. Depends on lcdns_pkg.
`default_nettype none
module lcdns_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             desc_valid,
  input  wire lcdns_pkg::desc_t desc,
  output logic                  desc_pop,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output logic                  out_register_select,
  output logic [3:0]            out_nibble,
  output logic [17:0]           out_wait_us,
  output logic                  out_last
);

  logic             busy_r, busy_nxt;
  lcdns_pkg::desc_t cur_r;
  lcdns_pkg::step_t step_r, step_nxt;
  logic             pre_r, pre_nxt;
  logic             low_r, low_nxt;
  logic [5:0]       reps_r, reps_nxt;
  logic             ovalid_r, ovalid_nxt;

  logic             emit;
  logic             s_rs, s_last;
  logic [3:0]       s_nib;
  logic [17:0]      s_wait;
  logic [7:0]       s_byte;

  assign out_empty = !ovalid_r;
  assign desc_pop  = !busy_r && desc_valid;
  assign emit      = busy_r && (!ovalid_r || out_pop);

  // current strobe
  always_comb begin
    s_byte = pre_r ? cur_r.byte_a : cur_r.byte_b;
    if (cur_r.kind == lcdns_pkg::KIND_INIT) begin
      s_rs   = 1'b0;
      s_nib  = lcdns_pkg::init_nibble(step_r, cur_r.fs);
      s_wait = lcdns_pkg::init_wait(step_r);
      s_last = (step_r == lcdns_pkg::INIT_LAST);
    end else begin
      s_rs   = cur_r.rs;
      s_nib  = low_r ? s_byte[3:0] : s_byte[7:4];
      s_wait = (low_r && !pre_r) ? cur_r.wait_b : 18'd0;
      s_last = low_r && !pre_r && (reps_r == 6'd1);
    end
  end

  // sequencer next state
  always_comb begin
    busy_nxt   = busy_r;
    step_nxt   = step_r;
    pre_nxt    = pre_r;
    low_nxt    = low_r;
    reps_nxt   = reps_r;
    ovalid_nxt = ovalid_r && !out_pop;
    if (desc_pop) begin
      busy_nxt = 1'b1;
      step_nxt = 4'd0;
      pre_nxt  = desc.pre;
      low_nxt  = 1'b0;
      reps_nxt = desc.reps;
    end else if (emit) begin
      ovalid_nxt = 1'b1;
      step_nxt   = step_r + 4'd1;
      low_nxt    = !low_r;
      if (low_r) begin
        if (pre_r) begin
          pre_nxt = 1'b0;
        end else begin
          reps_nxt = reps_r - 6'd1;
        end
      end
      if (s_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
      step_r   <= 4'd0;
      pre_r    <= 1'b0;
      low_r    <= 1'b0;
      reps_r   <= 6'd0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
      step_r   <= step_nxt;
      pre_r    <= pre_nxt;
      low_r    <= low_nxt;
      reps_r   <= reps_nxt;
    end
  end

  // descriptor and result payload
  always_ff @(posedge clk) begin
    if (desc_pop) begin
      cur_r <= desc;
    end
    if (emit) begin
      out_register_select <= s_rs;
      out_nibble          <= s_nib;
      out_wait_us         <= s_wait;
      out_last            <= s_last;
    end
  end

endmodule
`default_nettype wire

@@ rtl/char_lcd_nibble_sequencer_top.sv @@
// Top level of the character LCD nibble sequencer: configuration
// registers, front end and back end. Depends on lcdns_pkg.
//
// Usage: requests enter as queue pushes (in_push while in_full is low).
// Each one becomes a run of 4-bit strobes read out as queue pops: while
// out_empty is low the oldest strobe is on the out_ ports and out_pop takes
// it. out_last marks the final strobe of a request. Unknown operations and
// zero-length scrolls yield no strobes.
// An accepted request is written into the queue, loaded into the back end's
// descriptor register, then sent strobe by strobe into the result register.
// One strobe per cycle goes out unless the receiver stalls or a descriptor
// loads; init gives 12, byte or clear 2, cursor move 4, n-step scroll 2n.
// The two-entry queue between front and back takes new requests while the
// back end works. When the receiver stalls, the result register holds its
// strobe and the back end waits; the queue fills and in_full rises.
// Reset empties the queue and result register and sets rows=2, columns=16,
// large_font=0. Configuration is a plain write: cfg_we, cfg_index, cfg_data.
`default_nettype none
module char_lcd_nibble_sequencer_top #(
  parameter int MAX_SCROLL = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [5:0]  cfg_data,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [2:0]  in_operation,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic [1:0]  in_line,
  input  wire logic [5:0]  in_column,
  input  wire logic [5:0]  in_repeat_count,
  input  wire logic [7:0]  in_pause_ms,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic             out_register_select,
  output logic [3:0]       out_nibble,
  output logic [17:0]      out_wait_us,
  output logic             out_last
);

  logic [2:0]       rows_r;
  logic [5:0]       columns_r;
  logic             font_r;
  logic             desc_valid, desc_pop;
  lcdns_pkg::desc_t desc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= 3'd2;
      columns_r <= 6'd16;
      font_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        lcdns_pkg::CFG_ROWS:    rows_r    <= cfg_data[2:0];
        lcdns_pkg::CFG_COLUMNS: columns_r <= cfg_data;
        lcdns_pkg::CFG_FONT:    font_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lcdns_front #(
    .MAX_SCROLL(MAX_SCROLL)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_operation    (in_operation),
    .in_byte_value   (in_byte_value),
    .in_line         (in_line),
    .in_column       (in_column),
    .in_repeat_count (in_repeat_count),
    .in_pause_ms     (in_pause_ms),
    .rows            (rows_r),
    .columns         (columns_r),
    .large_font      (font_r),
    .desc_valid      (desc_valid),
    .desc            (desc),
    .desc_pop        (desc_pop)
  );

  lcdns_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .desc_valid          (desc_valid),
    .desc                (desc),
    .desc_pop            (desc_pop),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_register_select (out_register_select),
    .out_nibble          (out_nibble),
    .out_wait_us         (out_wait_us),
    .out_last            (out_last)
  );

endmodule
`default_nettype wire

@@ verif/char_lcd_nibble_sequencer_top_test.sv @@
// Self-checking testbench for char_lcd_nibble_sequencer_top: queued display requests in,
// predicted LCD strobe beats compared against the popped output beats.
// Depends on lcdns_pkg and the RTL top level only.
module char_lcd_nibble_sequencer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // codes the block must ignore, and the spare register index
  localparam logic [2:0] OP_SPARE6  = 3'd6;
  localparam logic [2:0] OP_SPARE7  = 3'd7;
  localparam logic [1:0] CFG_SPARE  = 2'd3;
  localparam int         SCROLL_CAP = 32;
  localparam int         TAIL_CYCLES = 16;
  localparam int         PHASES     = 8;
  localparam int         RAND_HALF  = 27;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] byte_value;
    logic [1:0] line;
    logic [5:0] column;
    logic [5:0] repeat_count;
    logic [7:0] pause_ms;
  } lcd_req_t;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nib;
    logic [17:0] wait_us;
    logic        last;
  } strobe_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [5:0]  cfg_data = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [2:0]  in_operation = '0;
  logic [7:0]  in_byte_value = '0;
  logic [1:0]  in_line = '0;
  logic [5:0]  in_column = '0;
  logic [5:0]  in_repeat_count = '0;
  logic [7:0]  in_pause_ms = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_register_select;
  logic [3:0]  out_nibble;
  logic [17:0] out_wait_us;
  logic        out_last;

  // local copy of the configuration, reset values
  logic [2:0]  lcd_rows = 3'd2;
  logic [5:0]  lcd_columns = 6'd16;
  logic        lcd_large_font = 1'b0;

  lcd_req_t    pending_reqs[$];
  strobe_t     strobe_expect_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;

  // per-phase settings: rows, columns, font, sender idle %, receiver stall %
  int unsigned ph_rows[PHASES]  = '{2, 1, 4, 0, 7, 3, 2, 5};
  int unsigned ph_cols[PHASES]  = '{16, 1, 40, 0, 63, 20, 16, 8};
  int unsigned ph_font[PHASES]  = '{0, 1, 0, 1, 1, 0, 1, 0};
  int unsigned ph_sidle[PHASES] = '{0, 54, 0, 11, 0, 54, 0, 11};
  int unsigned ph_rstal[PHASES] = '{0, 0, 54, 11, 0, 0, 54, 11};

  char_lcd_nibble_sequencer_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_operation        (in_operation),
    .in_byte_value       (in_byte_value),
    .in_line             (in_line),
    .in_column           (in_column),
    .in_repeat_count     (in_repeat_count),
    .in_pause_ms         (in_pause_ms),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_register_select (out_register_select),
    .out_nibble          (out_nibble),
    .out_wait_us         (out_wait_us),
    .out_last            (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------- strobe prediction ----------------
  function automatic void push_nibble(input logic rs, input logic [3:0] nib,
                                      input logic [17:0] w, input logic fin);
    strobe_expect_q.push_back({rs, nib, w, fin});
  endfunction

  // a byte goes out high nibble first; only the low nibble carries the wait
  function automatic void push_byte(input logic rs, input logic [7:0] b,
                                    input logic [17:0] w, input logic fin);
    push_nibble(rs, b[7:4], 18'd0, 1'b0);
    push_nibble(rs, b[3:0], w, fin);
  endfunction

  function automatic void predict_strobes(input lcd_req_t q);
    logic [3:0]  fs;
    logic [5:0]  maxc;
    logic [5:0]  col;
    logic [6:0]  off;
    logic [7:0]  addr;
    logic [17:0] w;
    int          cnt;
    fs   = ((lcd_rows > 3'd1) ? lcdns_pkg::FS_LINES : 4'h0)
         | (lcd_large_font ? lcdns_pkg::FS_FONT : 4'h0);
    maxc = (lcd_columns == 6'd0) ? 6'd0 : lcd_columns - 6'd1;
    col  = (q.column > maxc) ? maxc : q.column;
    case (q.line)
      2'd0:    off = lcdns_pkg::OFF_LINE0;
      2'd1:    off = lcdns_pkg::OFF_LINE1;
      2'd2:    off = lcdns_pkg::OFF_LINE2;
      default: off = lcdns_pkg::OFF_LINE3;
    endcase
    // address wraps to 7 bits when columns are out of range
    addr = {1'b1, 7'(col + off)};
    w    = 18'(int'(q.pause_ms) * 1000);
    cnt  = (q.repeat_count > SCROLL_CAP) ? SCROLL_CAP : int'(q.repeat_count);
    case (q.op)
      lcdns_pkg::OP_INIT: begin
        push_nibble(1'b0, lcdns_pkg::NIB_WAKE, 18'd5000, 1'b0);
        push_nibble(1'b0, lcdns_pkg::NIB_WAKE, 18'd100, 1'b0);
        push_nibble(1'b0, lcdns_pkg::NIB_WAKE, 18'd5000, 1'b0);
        push_nibble(1'b0, lcdns_pkg::NIB_4BIT, 18'd0, 1'b0);
        push_nibble(1'b0, lcdns_pkg::NIB_4BIT, 18'd0, 1'b0);
        push_nibble(1'b0, fs, 18'd60, 1'b0);
        push_byte(1'b0, lcdns_pkg::BYTE_DISPLAY, 18'd60, 1'b0);
        push_byte(1'b0, lcdns_pkg::BYTE_CLEAR, 18'd1000, 1'b0);
        push_byte(1'b0, lcdns_pkg::BYTE_ENTRY, 18'd0, 1'b1);
      end
      lcdns_pkg::OP_CMD:   push_byte(1'b0, q.byte_value, 18'd0, 1'b1);
      lcdns_pkg::OP_DATA:  push_byte(1'b1, q.byte_value, 18'd0, 1'b1);
      lcdns_pkg::OP_CLEAR: push_byte(1'b0, lcdns_pkg::BYTE_CLEAR, 18'd1000, 1'b1);
      lcdns_pkg::OP_CURSOR: begin
        push_byte(1'b0, lcdns_pkg::BYTE_HOME, 18'd0, 1'b0);
        push_byte(1'b0, addr, 18'd0, 1'b1);
      end
      lcdns_pkg::OP_SCROLL: begin
        for (int i = 0; i < cnt; i++)
          push_byte(1'b0, lcdns_pkg::BYTE_SCROLL, w, i == cnt - 1);
      end
      default: ;  // unknown codes produce nothing
    endcase
  endfunction

  // ---------------- request generation ----------------
  function automatic lcd_req_t mk_req(input logic [2:0] op, input logic [7:0] bv,
                                      input logic [1:0] ln, input logic [5:0] col,
                                      input logic [5:0] cnt, input logic [7:0] pms);
    return '{op, bv, ln, col, cnt, pms};
  endfunction

  function automatic lcd_req_t random_req();
    lcd_req_t    q;
    int unsigned pick;
    q.byte_value   = 8'($urandom_range(255));
    q.line         = 2'($urandom_range(3));
    q.column       = 6'($urandom_range(63));
    q.pause_ms     = 8'($urandom_range(255));
    // short scrolls mostly; now and then a long or saturating one
    q.repeat_count = ($urandom_range(99) < 6) ? 6'($urandom_range(63))
                                              : 6'($urandom_range(4));
    pick = $urandom_range(99);
    if (pick < 4)       q.op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
    else if (pick < 10) q.op = lcdns_pkg::OP_INIT;
    else if (pick < 30) q.op = lcdns_pkg::OP_CMD;
    else if (pick < 55) q.op = lcdns_pkg::OP_DATA;
    else if (pick < 62) q.op = lcdns_pkg::OP_CLEAR;
    else if (pick < 80) q.op = lcdns_pkg::OP_CURSOR;
    else                q.op = lcdns_pkg::OP_SCROLL;
    return q;
  endfunction

  // ---------------- request driver ----------------
  always @(posedge clk) begin : req_driver
    logic go;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        predict_strobes({in_operation, in_byte_value, in_line, in_column,
                         in_repeat_count, in_pause_ms});
        void'(pending_reqs.pop_front());
      end
      go = (pending_reqs.size() != 0) && ($urandom_range(99) >= send_idle_pct);
      in_push <= go;
      if (go) begin
        in_operation    <= pending_reqs[0].op;
        in_byte_value   <= pending_reqs[0].byte_value;
        in_line         <= pending_reqs[0].line;
        in_column       <= pending_reqs[0].column;
        in_repeat_count <= pending_reqs[0].repeat_count;
        in_pause_ms     <= pending_reqs[0].pause_ms;
      end
    end
  end

  // ---------------- strobe monitor ----------------
  always @(posedge clk) begin : strobe_monitor
    strobe_t got;
    strobe_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        got = {out_register_select, out_nibble, out_wait_us, out_last};
        if (strobe_expect_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected beat: expected none, actual rs=%0b nib=%h wait=%0d last=%0b",
                   $realtime, got.rs, got.nib, got.wait_us, got.last);
        end else begin
          want = strobe_expect_q.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: beat mismatch: expected rs=%0b nib=%h wait=%0d last=%0b,",
                     $realtime, want.rs, want.nib, want.wait_us, want.last);
            $display("%0t:   actual rs=%0b nib=%h wait=%0d last=%0b",
                     $realtime, got.rs, got.nib, got.wait_us, got.last);
          end
        end
      end
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------- sequencing ----------------
  // wait until every queued request is taken and every beat has come back
  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_push || strobe_expect_q.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // back-to-back register writes; upper data bits are junk to check masking
  task automatic apply_settings(input logic [2:0] r, input logic [5:0] c, input logic f);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= lcdns_pkg::CFG_ROWS;
    cfg_data  <= {3'($urandom_range(7)), r};
    @(posedge clk);
    cfg_index <= lcdns_pkg::CFG_COLUMNS;
    cfg_data  <= c;
    @(posedge clk);
    cfg_index <= lcdns_pkg::CFG_FONT;
    cfg_data  <= {5'($urandom_range(31)), f};
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data  <= 6'($urandom_range(63));
    @(posedge clk);
    cfg_we    <= 1'b0;
    lcd_rows       = r;
    lcd_columns    = c;
    lcd_large_font = f;
  endtask

  initial begin
    @(posedge rst_n);
    @(negedge clk);

    // directed: field extremes, every request, ignored codes, scroll edge cases
    pending_reqs.push_back(mk_req(lcdns_pkg::OP_INIT,   8'h00, 2'd0, 6'd0,  6'd0,  8'h00));
    pending_reqs.push_back(mk_req(lcdns_pkg::OP_CMD,    8'h00, 2'd0, 6'd0,  6'd0,  8'h00));
    pending_reqs.push_back(mk_req(lcdns_pkg::OP_CMD,    8'hFF, 2'd3, 6'd63, 6'd63, 8'hFF));
    pending_reqs.push_back(mk_req(lcdns_pkg::OP_DATA,   8'h00, 2'd0, 6'd0,  6'd0,  8'h00));
    pending_reqs.push_back(mk_req(lcdns_pkg::OP_DATA,   8'hFF, 2'd3, 6'd63, 6'd63, 8'hFF));
    pending_reqs.push_back(mk_req(lcdns_pkg::OP_DATA,   8'hA5, 2'd1, 6'd21, 6'd2,  8'h5A));
    pending_reqs.push_back(mk_req(lcdns_pkg::OP_CLEAR,  8'hFF, 2'd3, 6'd63, 6'd63, 8'hFF));
    pending_reqs.push_back(mk_req(lcdns_pkg::OP_CURSOR, 8'h00, 2'd0, 6'd0,  6'd0,  8'h00));
    pending_reqs.push_back(mk_req(lcdns_pkg::OP_CURSOR, 8'h00, 2'd1, 6'd63, 6'd0,  8'h00));
    pending_reqs.push_back(mk_req(lcdns_pkg::OP_CURSOR, 8'h00, 2'd2, 6'd15, 6'd0,  8'h00));
    pending_reqs.push_back(mk_req(lcdns_pkg::OP_CURSOR, 8'h00, 2'd3, 6'd5,  6'd0,  8'h00));
    pending_reqs.push_back(mk_req(lcdns_pkg::OP_SCROLL, 8'h00, 2'd0, 6'd0,  6'd0,  8'hFF));
    pending_reqs.push_back(mk_req(lcdns_pkg::OP_SCROLL, 8'h00, 2'd0, 6'd0,  6'd1,  8'h00));
    pending_reqs.push_back(mk_req(lcdns_pkg::OP_SCROLL, 8'h00, 2'd0, 6'd0,  6'd1,  8'hFF));
    pending_reqs.push_back(mk_req(lcdns_pkg::OP_SCROLL, 8'h00, 2'd0, 6'd0,  6'd32, 8'h01));
    pending_reqs.push_back(mk_req(lcdns_pkg::OP_SCROLL, 8'h00, 2'd0, 6'd0,  6'd33, 8'h80));
    pending_reqs.push_back(mk_req(lcdns_pkg::OP_SCROLL, 8'hFF, 2'd3, 6'd63, 6'd63, 8'h07));
    pending_reqs.push_back(mk_req(OP_SPARE6,            8'hFF, 2'd3, 6'd63, 6'd63, 8'hFF));
    pending_reqs.push_back(mk_req(OP_SPARE7,            8'h00, 2'd0, 6'd0,  6'd1,  8'h00));
    pending_reqs.push_back(mk_req(lcdns_pkg::OP_CMD,    8'h3C, 2'd2, 6'd42, 6'd5,  8'hC3));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0)
        apply_settings(3'(ph_rows[p]), 6'(ph_cols[p]), ph_font[p][0]);
      @(negedge clk);
      send_idle_pct  = ph_sidle[p];
      recv_stall_pct = ph_rstal[p];
      // each setting: power-up, then cursor moves that hit the clamp and, with wide rows, the wrap
      pending_reqs.push_back(mk_req(lcdns_pkg::OP_INIT, 8'($urandom_range(255)),
                                    2'd0, 6'd0, 6'd0, 8'h00));
      pending_reqs.push_back(mk_req(lcdns_pkg::OP_CURSOR, 8'h00, 2'd3, 6'd63, 6'd0, 8'h00));
      pending_reqs.push_back(mk_req(lcdns_pkg::OP_CURSOR, 8'h00, 2'd1, 6'd40, 6'd0, 8'h00));
      for (int i = 0; i < RAND_HALF; i++)
        pending_reqs.push_back(random_req());
      // sender holds off until the block has fully emptied
      drain();
      for (int i = 0; i < RAND_HALF; i++)
        pending_reqs.push_back(random_req());
      drain();
    end

    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
